FILE: design/psw_pkg.sv
// Shared constants and types of the per-source window share marker.
package psw_pkg;

  localparam int unsigned WINDOW_DEPTH = 2048;
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int unsigned MAX_FLOWS    = 64;
  localparam int unsigned FLOW_AW      = $clog2(MAX_FLOWS);

  localparam int unsigned LEN_W  = 12;  // window length, counts, share
  localparam int unsigned DIST_W = 7;   // distinct source count
  localparam int unsigned ADDR_W = 32;

  localparam logic [LEN_W-1:0] WL_RESET  = 12'd2000;
  localparam logic [LEN_W-1:0] THR_RESET = 12'd15;

  // Register indexes of the write port.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_MAX_THRESHOLD = 1'b1;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  dividend;
    logic [DIST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quotient;
  } div_rsp_t;

  // Window length saturated to the store depth.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wl);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(WINDOW_DEPTH);
    return (wl > lim) ? lim : wl;
  endfunction

endpackage

FILE: design/psw_div.sv
// Restoring divider for the fair share, one quotient bit per cycle.
module psw_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psw_pkg::div_req_t  req_i,
  output psw_pkg::div_rsp_t  rsp_o
);
  import psw_pkg::*;

  localparam int unsigned CNT_W = $clog2(LEN_W + 1);

  logic [DIST_W:0]   rem_q, rem_d;
  logic [LEN_W-1:0]  quo_q, quo_d;
  logic [DIST_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DIST_W:0]   trial;
  logic [DIST_W:0]   diff;

  always_comb begin
    trial = {rem_q[DIST_W-1:0], quo_q[LEN_W-1]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff;
      quo_d = {quo_q[LEN_W-2:0], 1'b1};
    end else begin
      rem_d = trial;
      quo_d = {quo_q[LEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(LEN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: design/per_source_window_share_marker_core.sv
// Top level of the per-source window share marker: sequencer, flow table and window store.
//
//  channel   | direction | transfer when              | contents
//  s_axis    | in        | s_axis_tvalid & tready     | tuser: mode, tdata: address, occupancy
//  m_axis    | out       | m_axis_tvalid & tready     | tdata: mark, count, distinct, share, full
//  cfg       | in        | cfg_we_i                   | cfg_idx_i selects, cfg_data_i value
//
// Every flow table search walks all 64 entries through one registered read port.
// An arrival is one search. A departure runs one search per evicted window entry,
// one search for the source itself, and a division when the distinct count changes.
// One item at a time: s_axis_tready is high only when the sequencer is idle and
// the previous result has been taken. Reset clears control, the flow valid bits
// and the counters at once; no clearing pass runs, the window store is never
// read before it is written.
module per_source_window_share_marker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] source_address, [43:32] queue_occupancy
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] mark, [12:1] source_count, [19:13] distinct_sources,
  // [31:20] fair_share, [32] table_full
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [psw_pkg::LEN_W-1:0] cfg_data_i
);
  import psw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVCHK, ST_EVKEY, ST_SCAN, ST_FIN, ST_DIV, ST_OUT
  } state_e;

  typedef enum logic [1:0] {PUR_ARR, PUR_EV, PUR_PUSH} purpose_e;

  localparam int unsigned FLOW_DW = ADDR_W + LEN_W;

  state_e   state_q;
  purpose_e pur_q;

  // configuration
  logic [LEN_W-1:0] wl_q, thr_q;
  // item
  logic             mode_q;
  logic [ADDR_W-1:0] addr_q, key_q;
  logic [LEN_W-1:0] occ_q;
  // window
  logic [WIN_AW-1:0] head_q;
  logic [LEN_W-1:0]  fill_q;
  logic [ADDR_W-1:0] window_mem [WINDOW_DEPTH];
  logic [ADDR_W-1:0] win_rd_q;
  // flow table
  logic [FLOW_DW-1:0] flow_mem [MAX_FLOWS];
  logic [FLOW_DW-1:0] flow_rd_q;
  logic [MAX_FLOWS-1:0] flow_vld_q;
  logic [DIST_W-1:0] distinct_q;
  logic [LEN_W-1:0]  share_q;
  // search
  logic [FLOW_AW:0]   scan_q;
  logic               cmp_vld_q;
  logic [FLOW_AW-1:0] cmp_idx_q;
  logic               hit_q, free_q;
  logic [FLOW_AW-1:0] hit_idx_q, free_idx_q;
  logic [LEN_W-1:0]   hit_cnt_q;
  // result
  logic             changed_q;
  logic             mark_q, full_q;
  logic [LEN_W-1:0] count_q;

  // combinational
  logic [LEN_W-1:0]   len;
  logic               scan_done;
  logic               have_entry;
  logic [FLOW_AW-1:0] tgt_idx;
  logic [LEN_W-1:0]   inc_cnt, dec_cnt, arr_cnt;
  logic               flow_we, win_we;
  logic [FLOW_AW-1:0] flow_wa;
  logic [FLOW_DW-1:0] flow_wd;
  logic [WIN_AW-1:0]  win_wa;
  logic               live;
  logic [ADDR_W-1:0]  rd_addr;
  logic [LEN_W-1:0]   rd_cnt;
  logic [LEN_W+2:0]   cnt_x5;
  logic [LEN_W+2:0]   share_x3;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  always_comb begin
    len        = eff_len(wl_q);
    scan_done  = (state_q == ST_SCAN) && scan_q[FLOW_AW] && !cmp_vld_q;
    have_entry = hit_q || free_q;
    tgt_idx    = hit_q ? hit_idx_q : free_idx_q;
    inc_cnt    = hit_q ? hit_cnt_q + 1'b1 : LEN_W'(1);
    dec_cnt    = hit_cnt_q - 1'b1;
    arr_cnt    = hit_q ? hit_cnt_q : '0;
    // count > floor(3*share/5) is the same as 5*count > 3*share
    cnt_x5     = {1'b0, arr_cnt, 2'b00} + {3'b000, arr_cnt};
    share_x3   = {2'b00, share_q, 1'b0} + {3'b000, share_q};
    rd_addr    = flow_rd_q[FLOW_DW-1:LEN_W];
    rd_cnt     = flow_rd_q[LEN_W-1:0];
    live       = flow_vld_q[cmp_idx_q] && (rd_cnt != '0);

    flow_we = scan_done && (((pur_q == PUR_EV) && hit_q) ||
                            ((pur_q == PUR_PUSH) && have_entry));
    flow_wa = (pur_q == PUR_EV) ? hit_idx_q : tgt_idx;
    flow_wd = (pur_q == PUR_EV) ? {key_q, dec_cnt} : {key_q, inc_cnt};
    win_we  = scan_done && (pur_q == PUR_PUSH) && have_entry;
    win_wa  = head_q + fill_q[WIN_AW-1:0];

    div_req.start    = (state_q == ST_FIN) && changed_q && (distinct_q != '0);
    div_req.dividend = len;
    div_req.divisor  = distinct_q;
  end

  psw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Flow table and window store: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (flow_we) begin
      flow_mem[flow_wa] <= flow_wd;
    end
    flow_rd_q <= flow_mem[scan_q[FLOW_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      window_mem[win_wa] <= addr_q;
    end
    win_rd_q <= window_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pur_q      <= PUR_ARR;
      wl_q       <= WL_RESET;
      thr_q      <= THR_RESET;
      head_q     <= '0;
      fill_q     <= '0;
      flow_vld_q <= '0;
      distinct_q <= '0;
      share_q    <= eff_len(WL_RESET);
      scan_q     <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      changed_q  <= 1'b0;
      mark_q     <= 1'b0;
      full_q     <= 1'b0;
      count_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q    <= s_axis_tuser;
            addr_q    <= s_axis_tdata[ADDR_W-1:0];
            key_q     <= s_axis_tdata[ADDR_W-1:0];
            occ_q     <= s_axis_tdata[ADDR_W+LEN_W-1:ADDR_W];
            changed_q <= 1'b0;
            mark_q    <= 1'b0;
            full_q    <= 1'b0;
            count_q   <= '0;
            scan_q    <= '0;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            if (s_axis_tuser) begin
              pur_q   <= PUR_ARR;
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_EVCHK;
            end
          end
        end
        ST_EVCHK: begin
          // trim oldest entries until there is room for one more
          if ((fill_q != '0) && (fill_q >= len)) begin
            head_q  <= head_q + 1'b1;
            fill_q  <= fill_q - 1'b1;
            state_q <= ST_EVKEY;
          end else if (len == '0) begin
            changed_q <= 1'b1;
            state_q   <= ST_FIN;
          end else begin
            key_q   <= addr_q;
            pur_q   <= PUR_PUSH;
            scan_q  <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_EVKEY: begin
          key_q   <= win_rd_q;
          pur_q   <= PUR_EV;
          scan_q  <= '0;
          hit_q   <= 1'b0;
          free_q  <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!scan_q[FLOW_AW]) begin
            cmp_vld_q <= 1'b1;
            cmp_idx_q <= scan_q[FLOW_AW-1:0];
            scan_q    <= scan_q + 1'b1;
          end else begin
            cmp_vld_q <= 1'b0;
          end
          if (cmp_vld_q) begin
            if (live && (rd_addr == key_q)) begin
              hit_q     <= 1'b1;
              hit_idx_q <= cmp_idx_q;
              hit_cnt_q <= rd_cnt;
            end
            if (!live && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
          end
          if (scan_done) begin
            case (pur_q)
              PUR_ARR: begin
                count_q <= arr_cnt;
                mark_q  <= (cnt_x5 > share_x3) && (occ_q >= thr_q);
                state_q <= ST_OUT;
              end
              PUR_EV: begin
                if (hit_q && (dec_cnt == '0)) begin
                  if (distinct_q != '0) begin
                    distinct_q <= distinct_q - 1'b1;
                  end
                  changed_q <= 1'b1;
                end
                state_q <= ST_EVCHK;
              end
              PUR_PUSH: begin
                if (have_entry) begin
                  flow_vld_q[tgt_idx] <= 1'b1;
                  count_q <= inc_cnt;
                  fill_q  <= fill_q + 1'b1;
                  if (inc_cnt == LEN_W'(1)) begin
                    distinct_q <= distinct_q + 1'b1;
                    changed_q  <= 1'b1;
                  end
                end else begin
                  full_q <= 1'b1;
                end
                state_q <= ST_FIN;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_FIN: begin
          if (!changed_q) begin
            state_q <= ST_OUT;
          end else if (distinct_q == '0) begin
            share_q <= len;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            share_q <= div_rsp.quotient;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // configuration must arrive only while idle; the block itself does not enforce this
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WINDOW_LENGTH) begin
          wl_q    <= cfg_data_i;
          share_q <= eff_len(cfg_data_i);
        end else begin
          thr_q <= cfg_data_i;
        end
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {7'b0, full_q, share_q, distinct_q, count_q, mark_q};

  // Window never holds more than the store depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(WINDOW_DEPTH))
    else $error("window fill above depth");

  // Distinct sources never exceed the flow table size.
  a_distinct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= DIST_W'(MAX_FLOWS))
    else $error("distinct count above table size");

  // Departures are never marked.
  a_dep_no_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !mode_q) |-> !mark_q)
    else $error("departure marked");

  // A full table leaves the source uncounted.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && full_q) |-> (count_q == '0))
    else $error("table full with nonzero count");

  // Input and output sides are never open together.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("accept while result pending");

endmodule
